// ===== rtl/sobel_edge_magnitude_macros.svh =====
// assertion macros for the sobel edge magnitude block
`ifndef SOBEL_EDGE_MAGNITUDE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_MACROS_SVH
`ifndef ASSERT_OFF
`define SEM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define SEM_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("%m hit");
`else
`define SEM_ASSERT(label, clk, rst_n, prop)
`define SEM_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/sem_pkg.sv =====
package sem_pkg;
  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned RowW = 12;
  localparam int unsigned LwW = 11;
  localparam logic [LwW-1:0] LwReset = 11'd640;
  localparam logic [RowW-1:0] FhReset = 12'd480;
  localparam logic [0:0] RegLineWidth = 1'b0;
  localparam logic [0:0] RegFrameHeight = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_ROOT
  } state_e;

  typedef struct packed {
    logic start;
    logic compute;
    logic root_step;
  } sem_cmd_t;

  typedef struct packed {
    logic emit;
    logic root_done;
  } sem_stat_t;
endpackage

// ===== rtl/sem_ram.sv =====
module sem_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/sem_ctrl.sv =====
module sem_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_fire_i,
  input  logic               out_busy_i,
  input  sem_pkg::sem_stat_t stat_i,
  output sem_pkg::sem_cmd_t  cmd_o,
  output logic               in_ready_o
);
  sem_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= sem_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sem_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire_i) begin
          cmd_o.start = 1'b1;
          state_d = sem_pkg::ST_READ;
        end
      end
      sem_pkg::ST_READ: state_d = sem_pkg::ST_CALC;
      sem_pkg::ST_CALC: begin
        cmd_o.compute = 1'b1;
        state_d = stat_i.emit ? sem_pkg::ST_ROOT : sem_pkg::ST_IDLE;
      end
      sem_pkg::ST_ROOT: begin
        if (stat_i.root_done) begin
          if (!out_busy_i) state_d = sem_pkg::ST_IDLE;
        end else begin
          cmd_o.root_step = 1'b1;
        end
      end
      default: state_d = sem_pkg::ST_IDLE;
    endcase
  end
endmodule

// ===== rtl/sem_datapath.sv =====
module sem_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sem_pkg::sem_cmd_t         cmd_i,
  input  logic [7:0]                pixel_i,
  input  logic                      frame_start_i,
  input  logic [sem_pkg::LwW-1:0]   line_width_i,
  input  logic [sem_pkg::RowW-1:0]  frame_height_i,
  output sem_pkg::sem_stat_t        stat_o,
  output logic [7:0]                mag_o,
  output logic [sem_pkg::ColW-1:0]  col_o,
  output logic [sem_pkg::RowW-1:0]  row_o
);
  localparam int unsigned CW = sem_pkg::ColW;
  localparam int unsigned RW = sem_pkg::RowW;

  logic [CW-1:0] col_q, col_d, cur_col_q;
  logic [RW-1:0] row_q, row_d, cur_row_q;
  logic [7:0] px_q;
  logic [7:0] w_q [6];
  logic [7:0] up_rd, mid_rd;
  logic [CW-1:0] col_eff;
  logic [RW-1:0] row_eff;
  logic [sem_pkg::LwW-1:0] width;
  logic [RW-1:0] height;
  logic [17:0] sum_q;
  logic [7:0] root_q;
  logic [3:0] bit_q;
  logic signed [11:0] gx, gy;
  logic [21:0] sq_sum;
  logic emit;
  logic [8:0] trial;

  assign col_eff = frame_start_i ? '0 : col_q;
  assign row_eff = frame_start_i ? '0 : row_q;

  always_comb begin
    width = line_width_i;
    if (width < 11'd3) width = 11'd3;
    if (width > 11'(sem_pkg::MaxWidth)) width = 11'(sem_pkg::MaxWidth);
    height = (frame_height_i < 12'd3) ? 12'd3 : frame_height_i;
    col_d = col_eff + 1'b1;
    row_d = row_eff;
    if ({1'b0, col_eff} + 11'd1 >= width) begin
      col_d = '0;
      row_d = ({1'b0, row_eff} + 13'd1 >= {1'b0, height}) ? '0 : row_eff + 1'b1;
    end
  end

  // read address held in a register so the read data stays put until compute
  sem_ram #(.Width(8), .Depth(sem_pkg::MaxWidth)) u_upper (
    .clk_i, .we_i(cmd_i.compute), .waddr_i(cur_col_q), .wdata_i(mid_rd),
    .raddr_i(cur_col_q), .rdata_o(up_rd));
  sem_ram #(.Width(8), .Depth(sem_pkg::MaxWidth)) u_middle (
    .clk_i, .we_i(cmd_i.compute), .waddr_i(cur_col_q), .wdata_i(px_q),
    .raddr_i(cur_col_q), .rdata_o(mid_rd));

  // gradients over the window, right column from ram and current pixel
  always_comb begin
    gx = (12'(up_rd) - 12'(w_q[3])) + 12'((12'(mid_rd) - 12'(w_q[4])) <<< 1)
       + (12'(px_q) - 12'(w_q[5]));
    gy = (12'(w_q[5]) + 12'(12'(w_q[2]) << 1) + 12'(px_q))
       - (12'(w_q[3]) + 12'(12'(w_q[0]) << 1) + 12'(up_rd));
    sq_sum = 22'(22'(gx * gx) + 22'(gy * gy));
    emit = (cur_row_q >= 12'd2) && (cur_col_q >= 10'd2);
  end

  assign trial = {1'b0, root_q} | (9'd1 << bit_q);
  assign stat_o.emit = emit;
  assign stat_o.root_done = (bit_q == 4'hf);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      for (int i = 0; i < 6; i++) w_q[i] <= '0;
      bit_q <= 4'hf;
    end else begin
      if (cmd_i.start) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (cmd_i.compute) begin
        w_q[3] <= w_q[0];
        w_q[4] <= w_q[1];
        w_q[5] <= w_q[2];
        w_q[0] <= up_rd;
        w_q[1] <= mid_rd;
        w_q[2] <= px_q;
        bit_q <= sq_sum >= 22'd65536 ? 4'hf : 4'd7;
      end else if (cmd_i.root_step) begin
        bit_q <= (bit_q == 4'd0) ? 4'hf : bit_q - 1'b1;
      end
    end
  end

  // one result bit per cycle, msb first
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q <= pixel_i;
      cur_col_q <= col_eff;
      cur_row_q <= row_eff;
    end
    if (cmd_i.compute) begin
      sum_q <= sq_sum[17:0];
      root_q <= (sq_sum >= 22'd65536) ? 8'hff : 8'h00;
      col_o <= cur_col_q - 1'b1;
      row_o <= cur_row_q - 1'b1;
    end else if (cmd_i.root_step) begin
      if (18'(trial) * 18'(trial) <= sum_q) root_q <= trial[7:0];
    end
  end

  assign mag_o = root_q;
endmodule

// ===== rtl/sobel_edge_magnitude.sv =====
// sobel 3x3 gradient magnitude on a raster pixel stream
// border pixel: no result, next word taken once the controller has gone through read and calc back to idle
// interior pixel: result after the square-root loop, next word taken once that result is in the output register
// saturated sum skips the root loop: result and next word wait only for the output register to be free
// the isqrt loop, one result bit per cycle, makes interior pixels the slowest case
// reset: async active low, position and window clear, line width 640, height 480
`include "sobel_edge_magnitude_macros.svh"
module sobel_edge_magnitude (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // pixel[7:0]
  input  logic        s_axis_tuser,   // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // magnitude[7:0], out_col[17:8], out_row[29:18]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  sem_pkg::sem_cmd_t cmd;
  sem_pkg::sem_stat_t stat;
  logic in_fire;
  logic [sem_pkg::LwW-1:0] lw_q;
  logic [sem_pkg::RowW-1:0] fh_q;
  logic [7:0] mag;
  logic [sem_pkg::ColW-1:0] ocol;
  logic [sem_pkg::RowW-1:0] orow;
  logic out_valid_q;
  logic [31:0] out_data_q;
  logic done_pulse;
  logic root_active_q;

  assign cfg_ready_o = 1'b1;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q <= sem_pkg::LwReset;
      fh_q <= sem_pkg::FhReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == sem_pkg::RegLineWidth) lw_q <= cfg_data_i[10:0];
      else fh_q <= cfg_data_i[11:0];
    end
  end

  sem_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .out_busy_i(out_valid_q),
    .stat_i(stat), .cmd_o(cmd), .in_ready_o(s_axis_tready));

  sem_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .pixel_i(s_axis_tdata),
    .frame_start_i(s_axis_tuser), .line_width_i(lw_q), .frame_height_i(fh_q),
    .stat_o(stat), .mag_o(mag), .col_o(ocol), .row_o(orow));

  // result leaves the root unit once the output register is free
  assign done_pulse = stat.root_done && !cmd.root_step && !cmd.compute
                      && !s_axis_tready && !out_valid_q && root_active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_active_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd.compute && stat.emit) root_active_q <= 1'b1;
      else if (done_pulse) root_active_q <= 1'b0;
      if (done_pulse) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_pulse) out_data_q <= {2'b00, orow, ocol, mag};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;

  `SEM_ASSERT(a_done_needs_root, clk_i, rst_ni, done_pulse |-> root_active_q)
  `SEM_ASSERT_NEVER(a_accept_while_root, clk_i, rst_ni, in_fire && root_active_q)
  `SEM_ASSERT(a_out_after_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(done_pulse))
endmodule
